>>> src/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("implication check failed");

// Clocked check that a condition never holds outside reset.
`define CHK_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> src/gsgc_pkg.sv
// Shared types of the grid spot geodesic check.
package gsgc_pkg;

	// Neighbor directions, visited in this order for each dequeued pixel.
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	localparam int GRID_SIDE_W = 7;

endpackage

>>> src/gsgc_chan_if.sv
// Channel interfaces: pixel input, verdict output and side register write.
interface gsgc_pix_if;
	logic valid;
	logic ready;
	logic is_spot;
	logic last_pixel;
	modport source (output valid, output is_spot, output last_pixel, input ready);
	modport sink (input valid, input is_spot, input last_pixel, output ready);
endinterface

interface gsgc_vrd_if;
	logic valid;
	logic ready;
	logic regular;
	modport source (output valid, output regular, input ready);
	modport sink (input valid, input regular, output ready);
endinterface

interface gsgc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [gsgc_pkg::GRID_SIDE_W-1:0]    grid_side;
	modport source (output valid, output grid_side, input ready);
	modport sink (input valid, input grid_side, output ready);
endinterface

>>> src/gsgc_nbr.sv
// Neighbor address generator: one of the four grid neighbors of a pixel.
module gsgc_nbr #(
	parameter int CW = 6,
	parameter int SW = 7,
	parameter int AW = 12
) (
	input  gsgc_pkg::dir_t   dir,
	input  logic [AW-1:0]    cur_idx,
	input  logic [CW-1:0]    cur_row,
	input  logic [CW-1:0]    cur_col,
	input  logic [SW-1:0]    side,
	output logic             ok,
	output logic [AW-1:0]    idx,
	output logic [CW-1:0]    row,
	output logic [CW-1:0]    col
);

	logic [AW-1:0] stride;

	assign stride = AW'(side);

	always_comb begin
		ok  = 1'b0;
		idx = cur_idx;
		row = cur_row;
		col = cur_col;
		case (dir)
			gsgc_pkg::DIR_UP: begin
				ok  = (cur_row != '0);
				idx = cur_idx - stride;
				row = cur_row - CW'(1);
			end
			gsgc_pkg::DIR_DOWN: begin
				ok  = ((SW'(cur_row) + SW'(1)) < side);
				idx = cur_idx + stride;
				row = cur_row + CW'(1);
			end
			gsgc_pkg::DIR_LEFT: begin
				ok  = (cur_col != '0);
				idx = cur_idx - AW'(1);
				col = cur_col - CW'(1);
			end
			gsgc_pkg::DIR_RIGHT: begin
				ok  = ((SW'(cur_col) + SW'(1)) < side);
				idx = cur_idx + AW'(1);
				col = cur_col + CW'(1);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

>>> src/grid_spot_geodesic_check_unit.sv
// Grid spot geodesic check: loads a square image and checks spot geodesics.
// Load: one pixel per cycle; the next image is taken only after the verdict transfer.
// Search: a clearing pass over all MAX_SIDE*MAX_SIDE entries, then a read and check of each source
// pixel; from each spot source a breadth-first search over the queue, probing the four grid
// neighbors of each queued pixel, followed by a check sweep over every pixel.
// Reset (arst_n low) clears control state and sets the side register to 1.
module grid_spot_geodesic_check_unit #(
	parameter int MAX_SIDE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	gsgc_pix_if.sink           pix,
	gsgc_vrd_if.source         res,
	gsgc_cfg_if.sink           cfg
);

`include "assert_macros.svh"

	// Coordinate, side, address, position, distance and queue entry widths.
	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW = CW + 1;
	localparam int N  = MAX_SIDE * MAX_SIDE;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int PW = AW + 1;
	localparam int DW = AW;
	localparam int QW = AW + 2 * CW;

	typedef enum logic [3:0] {
		ST_LOAD, ST_CLR, ST_SRC_RD, ST_SRC_CHK, ST_SRC_NEXT, ST_Q_RD, ST_Q_WAIT,
		ST_Q_DIST, ST_NB_SEL, ST_NB_CHK, ST_CK_RD, ST_CK_EVAL, ST_DONE
	} state_t;

	state_t state_q;

	logic [gsgc_pkg::GRID_SIDE_W-1:0] side_q;
	logic [PW-1:0] load_pos_q;
	logic          verdict_q;
	logic          fail_q;
	logic [PW-1:0] clr_q;
	logic [AW-1:0] src_q;
	logic [CW-1:0] src_r_q, src_c_q;
	logic [AW-1:0] t_q;
	logic [CW-1:0] t_r_q, t_c_q;
	logic [PW-1:0] head_q, tail_q;
	logic [AW-1:0] cur_idx_q;
	logic [CW-1:0] cur_r_q, cur_c_q;
	logic [DW-1:0] cur_dist_q;
	logic [AW-1:0] m_idx_q;
	logic [CW-1:0] m_r_q, m_c_q;
	gsgc_pkg::dir_t dir_q;

	// Single-port state memories, each with a registered read.
	logic          img_mem [N];
	logic          vis_mem [N];
	logic [DW-1:0] dist_mem [N];
	logic [QW-1:0] queue_mem [N];

	logic          img_we, img_wd, img_rd_q;
	logic [AW-1:0] img_addr;
	logic          vis_we, vis_wd, vis_rd_q;
	logic [AW-1:0] vis_addr;
	logic          dist_we;
	logic [DW-1:0] dist_wd, dist_rd_q;
	logic [AW-1:0] dist_addr;
	logic          q_we;
	logic [QW-1:0] q_wd, q_rd_q;
	logic [AW-1:0] q_addr;

	// The side in force: zero reads as one, anything above MAX_SIDE as MAX_SIDE.
	logic [SW-1:0] side_eff;
	logic [PW-1:0] n_cells, n_last;

	always_comb begin
		if (side_q == '0) begin
			side_eff = SW'(1);
		end else if (32'(side_q) > MAX_SIDE) begin
			side_eff = SW'(MAX_SIDE);
		end else begin
			side_eff = SW'(side_q);
		end
	end

	assign n_cells = PW'(side_eff) * PW'(side_eff);
	assign n_last  = n_cells - PW'(1);

	logic          nb_ok;
	logic [AW-1:0] nb_idx;
	logic [CW-1:0] nb_r, nb_c;

	gsgc_nbr #(.CW(CW), .SW(SW), .AW(AW)) u_nbr (
		.dir     (dir_q),
		.cur_idx (cur_idx_q),
		.cur_row (cur_r_q),
		.cur_col (cur_c_q),
		.side    (side_eff),
		.ok      (nb_ok),
		.idx     (nb_idx),
		.row     (nb_r),
		.col     (nb_c)
	);

	// Manhattan distance between the current source and the swept pixel.
	logic [CW-1:0] dr, dc;
	logic [DW-1:0] manh;
	logic          ck_bad, fail_next;

	assign dr        = (src_r_q > t_r_q) ? (src_r_q - t_r_q) : (t_r_q - src_r_q);
	assign dc        = (src_c_q > t_c_q) ? (src_c_q - t_c_q) : (t_c_q - src_c_q);
	assign manh      = DW'(dr) + DW'(dc);
	assign ck_bad    = img_rd_q && (!vis_rd_q || (dist_rd_q != manh));
	assign fail_next = fail_q || ck_bad;

	// A newly found spot pixel: a spot that this search has not yet visited.
	logic nb_new;
	assign nb_new = img_rd_q && !vis_rd_q;

	logic pix_xfer;
	assign pix_xfer = pix.valid && pix.ready;

	assign pix.ready   = (state_q == ST_LOAD);
	assign res.valid   = (state_q == ST_DONE);
	assign res.regular = verdict_q;
	assign cfg.ready   = 1'b1;

	// Port selection for the memories. Every state drives one address per memory, and
	// a write reads back the old contents of the entry that it writes.
	always_comb begin
		img_we    = 1'b0;
		img_wd    = pix.is_spot;
		img_addr  = load_pos_q[AW-1:0];
		vis_we    = 1'b0;
		vis_wd    = 1'b0;
		vis_addr  = t_q;
		dist_we   = 1'b0;
		dist_wd   = cur_dist_q + DW'(1);
		dist_addr = t_q;
		q_we      = 1'b0;
		q_wd      = {m_idx_q, m_r_q, m_c_q};
		q_addr    = tail_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				img_we = pix_xfer && (load_pos_q < n_cells);
			end
			ST_CLR: begin
				vis_we   = 1'b1;
				vis_addr = clr_q[AW-1:0];
			end
			ST_SRC_RD: begin
				img_addr = src_q;
			end
			ST_SRC_CHK: begin
				// Seed the search: mark the source, distance zero, queue slot zero.
				vis_we    = img_rd_q;
				vis_wd    = 1'b1;
				vis_addr  = src_q;
				dist_we   = img_rd_q;
				dist_wd   = '0;
				dist_addr = src_q;
				q_we      = img_rd_q;
				q_wd      = {src_q, src_r_q, src_c_q};
				q_addr    = '0;
			end
			ST_Q_RD: begin
				q_addr = head_q[AW-1:0];
			end
			ST_Q_WAIT: begin
				dist_addr = q_rd_q[QW-1 -: AW];
			end
			ST_NB_SEL: begin
				img_addr = nb_idx;
				vis_addr = nb_idx;
			end
			ST_NB_CHK: begin
				vis_we    = nb_new;
				vis_wd    = 1'b1;
				vis_addr  = m_idx_q;
				dist_we   = nb_new;
				dist_addr = m_idx_q;
				q_we      = nb_new;
			end
			ST_CK_RD: begin
				img_addr = t_q;
			end
			ST_CK_EVAL: begin
				// The check sweep also clears the visited marks for the next source.
				vis_we = 1'b1;
			end
			default: begin
				img_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_addr] <= img_wd;
		end
		img_rd_q <= img_mem[img_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_addr] <= vis_wd;
		end
		vis_rd_q <= vis_mem[vis_addr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_addr] <= dist_wd;
		end
		dist_rd_q <= dist_mem[dist_addr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_addr] <= q_wd;
		end
		q_rd_q <= queue_mem[q_addr];
	end

	// Sequencer: load, clear, then for each spot source a breadth-first search
	// followed by a check sweep over the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			side_q     <= gsgc_pkg::GRID_SIDE_W'(1);
			load_pos_q <= '0;
			verdict_q  <= 1'b1;
			fail_q     <= 1'b0;
			clr_q      <= '0;
			src_q      <= '0;
			src_r_q    <= '0;
			src_c_q    <= '0;
			t_q        <= '0;
			t_r_q      <= '0;
			t_c_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cur_idx_q  <= '0;
			cur_r_q    <= '0;
			cur_c_q    <= '0;
			cur_dist_q <= '0;
			m_idx_q    <= '0;
			m_r_q      <= '0;
			m_c_q      <= '0;
			dir_q      <= gsgc_pkg::DIR_UP;
		end else begin
			if (cfg.valid) begin
				side_q <= cfg.grid_side;
			end
			case (state_q)
				ST_LOAD: begin
					// Pixels past the end of the image are dropped.
					if (pix_xfer) begin
						if (load_pos_q < n_cells) begin
							load_pos_q <= load_pos_q + PW'(1);
						end
						if (pix.last_pixel) begin
							clr_q   <= '0;
							state_q <= ST_CLR;
						end
					end
				end
				ST_CLR: begin
					if (clr_q == PW'(N - 1)) begin
						src_q     <= '0;
						src_r_q   <= '0;
						src_c_q   <= '0;
						verdict_q <= 1'b1;
						state_q   <= ST_SRC_RD;
					end else begin
						clr_q <= clr_q + PW'(1);
					end
				end
				ST_SRC_RD: begin
					state_q <= ST_SRC_CHK;
				end
				ST_SRC_CHK: begin
					if (img_rd_q) begin
						head_q  <= '0;
						tail_q  <= PW'(1);
						state_q <= ST_Q_RD;
					end else begin
						state_q <= ST_SRC_NEXT;
					end
				end
				ST_SRC_NEXT: begin
					if (PW'(src_q) == n_last) begin
						state_q <= ST_DONE;
					end else begin
						src_q <= src_q + AW'(1);
						if (SW'(src_c_q) == side_eff - SW'(1)) begin
							src_c_q <= '0;
							src_r_q <= src_r_q + CW'(1);
						end else begin
							src_c_q <= src_c_q + CW'(1);
						end
						state_q <= ST_SRC_RD;
					end
				end
				ST_Q_RD: begin
					if (head_q == tail_q) begin
						t_q     <= '0;
						t_r_q   <= '0;
						t_c_q   <= '0;
						fail_q  <= 1'b0;
						state_q <= ST_CK_RD;
					end else begin
						head_q  <= head_q + PW'(1);
						state_q <= ST_Q_WAIT;
					end
				end
				ST_Q_WAIT: begin
					cur_idx_q <= q_rd_q[QW-1 -: AW];
					cur_r_q   <= q_rd_q[2*CW-1 -: CW];
					cur_c_q   <= q_rd_q[CW-1:0];
					state_q   <= ST_Q_DIST;
				end
				ST_Q_DIST: begin
					cur_dist_q <= dist_rd_q;
					dir_q      <= gsgc_pkg::DIR_UP;
					state_q    <= ST_NB_SEL;
				end
				ST_NB_SEL: begin
					if (nb_ok) begin
						m_idx_q <= nb_idx;
						m_r_q   <= nb_r;
						m_c_q   <= nb_c;
						state_q <= ST_NB_CHK;
					end else if (dir_q == gsgc_pkg::DIR_RIGHT) begin
						state_q <= ST_Q_RD;
					end else begin
						dir_q <= gsgc_pkg::dir_t'(dir_q + 2'd1);
					end
				end
				ST_NB_CHK: begin
					if (nb_new) begin
						tail_q <= tail_q + PW'(1);
					end
					if (dir_q == gsgc_pkg::DIR_RIGHT) begin
						state_q <= ST_Q_RD;
					end else begin
						dir_q   <= gsgc_pkg::dir_t'(dir_q + 2'd1);
						state_q <= ST_NB_SEL;
					end
				end
				ST_CK_RD: begin
					state_q <= ST_CK_EVAL;
				end
				ST_CK_EVAL: begin
					// The sweep always runs to the end so that every mark is cleared.
					if (PW'(t_q) == n_last) begin
						if (fail_next) begin
							verdict_q <= 1'b0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_SRC_NEXT;
						end
					end else begin
						fail_q <= fail_next;
						t_q    <= t_q + AW'(1);
						if (SW'(t_c_q) == side_eff - SW'(1)) begin
							t_c_q <= '0;
							t_r_q <= t_r_q + CW'(1);
						end else begin
							t_c_q <= t_c_q + CW'(1);
						end
						state_q <= ST_CK_RD;
					end
				end
				ST_DONE: begin
					if (res.ready) begin
						load_pos_q <= '0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The queue head never passes its tail.
	`CHK_NEVER(a_head_le_tail, clk, arst_n, head_q > tail_q)
	// Pixel intake and verdict offer never overlap.
	`CHK_NEVER(a_no_load_while_verdict, clk, arst_n, res.valid && pix.ready)
	// A delivered verdict rewinds the load position.
	`CHK_IMPLY(a_rewind, clk, arst_n, (res.valid && res.ready) |=> (load_pos_q == '0))

endmodule
